>>> hw/rtl/ezvad_pkg.sv
// ----------------------------------------------------------------------------
// ezvad_pkg
// Shared types and constants of the energy and zero-crossing voice activity
// detector: payload structs, configuration layout and queue status.
// ----------------------------------------------------------------------------
package ezvad_pkg;

   // One input sample of a frame.
   typedef struct packed {
      logic signed [15:0] sample;
      logic               last_sample;
   } req_type;

   // One decision per closed frame.
   typedef struct packed {
      logic speaking;
      logic frame_voice;
   } rsp_type;

   // Configuration as seen by the decision unit.
   typedef struct packed {
      logic [15:0] energy_threshold;
      logic [16:0] zcr_threshold;
      logic [7:0]  hangover_frames;
   } cfg_type;

   // Frame queue occupancy.
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic       empty;
      logic       full;
      logic [1:0] level;
   } q_status_type;

   // Configuration register indexes (word address bits [3:2]).
   localparam logic [1:0] REG_ENERGY_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_ZCR_THRESHOLD    = 2'd1;
   localparam logic [1:0] REG_HANGOVER_FRAMES  = 2'd2;

   localparam logic [15:0] ENERGY_THRESHOLD_RESET = 16'd500;
   localparam logic [16:0] ZCR_THRESHOLD_RESET    = 17'd19661;
   localparam logic [7:0]  HANGOVER_FRAMES_RESET  = 8'd8;

   // Two active frames in a row declare speech.
   localparam logic [1:0] ACTIVE_RUN_SPEAK = 2'd2;
   localparam logic [7:0] SILENT_RUN_MAX   = 8'd255;

endpackage

>>> hw/rtl/ezvad_queue.sv
// ----------------------------------------------------------------------------
// ezvad_queue
// Two-entry frame queue between the accumulator and the decision unit.
// ----------------------------------------------------------------------------
module ezvad_queue #(
   parameter int unsigned WIDTH = 68
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        wdata,
   input  logic                    pop,
   output logic [WIDTH-1:0]        rdata,
   output ezvad_pkg::q_status_type status
);

   logic [WIDTH-1:0] entry_ff [ezvad_pkg::QUEUE_DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       level_ff, level_in;
   logic             do_push, do_pop;

   assign do_push = push && (level_ff != 2'(ezvad_pkg::QUEUE_DEPTH));
   assign do_pop  = pop && (level_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata        = entry_ff[rd_ptr_ff];
   assign status.empty = (level_ff == 2'd0);
   assign status.full  = (level_ff == 2'(ezvad_pkg::QUEUE_DEPTH));
   assign status.level = level_ff;

endmodule

>>> hw/rtl/ezvad_front.sv
// ----------------------------------------------------------------------------
// ezvad_front
// Sample accumulator: squares each sample, counts samples and sign changes,
// and hands each closed frame to the queue as one record.
// ----------------------------------------------------------------------------
module ezvad_front #(
   parameter int unsigned MAX_FRAME_LEN = 4096,
   localparam int unsigned CNT_W = $clog2(MAX_FRAME_LEN + 1),
   localparam int unsigned CRS_W = $clog2(MAX_FRAME_LEN),
   localparam int unsigned SUM_W = 30 + CNT_W,
   localparam int unsigned REC_W = SUM_W + CNT_W + CRS_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  ezvad_pkg::req_type      req_data,
   output logic                    req_stall,
   input  ezvad_pkg::q_status_type q_status,
   output logic                    q_push,
   output logic [REC_W-1:0]        q_wdata
);

   logic             accept;
   logic             negative;
   logic [15:0]      mag;
   logic [CNT_W-1:0] count_ff, count_in, count_inc;
   logic [CRS_W-1:0] cross_ff, cross_in, cross_inc;
   logic             prev_neg_ff, prev_neg_in;
   logic             close;
   // second stage: registered square and frame snapshot
   logic             sq_valid_ff, sq_valid_in;
   logic             close_ff, close_in;
   logic [31:0]      sq_ff, sq_in;
   logic [CNT_W-1:0] snap_n_ff, snap_n_in;
   logic [CRS_W-1:0] snap_c_ff, snap_c_in;
   logic [SUM_W-1:0] sum_ff, sum_in, sum_next;
   logic             pending;

   assign pending   = sq_valid_ff && close_ff;
   assign req_stall = (3'(q_status.level) + 3'(pending)) >= 3'(ezvad_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   assign negative  = req_data.sample[15];
   assign mag       = negative ? (16'd0 - $unsigned(req_data.sample))
                               : $unsigned(req_data.sample);
   assign count_inc = count_ff + CNT_W'(1);
   assign cross_inc = ((count_ff != '0) && (negative != prev_neg_ff))
                      ? cross_ff + CRS_W'(1) : cross_ff;
   assign close     = req_data.last_sample || (count_inc == CNT_W'(MAX_FRAME_LEN));

   always_comb begin
      count_in    = count_ff;
      cross_in    = cross_ff;
      prev_neg_in = prev_neg_ff;
      sq_valid_in = accept;
      close_in    = close_ff;
      sq_in       = sq_ff;
      snap_n_in   = snap_n_ff;
      snap_c_in   = snap_c_ff;
      if (accept) begin
         sq_in    = {16'd0, mag} * {16'd0, mag};
         close_in = close;
         if (close) begin
            // The frame ends here; its totals move to the second stage.
            snap_n_in   = count_inc;
            snap_c_in   = cross_inc;
            count_in    = '0;
            cross_in    = '0;
            prev_neg_in = 1'b0;
         end else begin
            count_in    = count_inc;
            cross_in    = cross_inc;
            prev_neg_in = negative;
         end
      end
   end

   assign sum_next = sum_ff + SUM_W'(sq_ff);

   always_comb begin
      sum_in = sum_ff;
      if (sq_valid_ff) begin
         sum_in = close_ff ? '0 : sum_next;
      end
   end

   assign q_push  = pending;
   assign q_wdata = {sum_next, snap_n_ff, snap_c_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         cross_ff    <= '0;
         prev_neg_ff <= 1'b0;
         sq_valid_ff <= 1'b0;
         close_ff    <= 1'b0;
         sum_ff      <= '0;
      end else begin
         count_ff    <= count_in;
         cross_ff    <= cross_in;
         prev_neg_ff <= prev_neg_in;
         sq_valid_ff <= sq_valid_in;
         close_ff    <= close_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff     <= sq_in;
      snap_n_ff <= snap_n_in;
      snap_c_ff <= snap_c_in;
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("frame record pushed into a full queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(MAX_FRAME_LEN))
      else $error("open frame reached the maximum length without closing");

   a_close_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && close) |=> (count_ff == '0) && (cross_ff == '0))
      else $error("frame counters not restarted after a closing sample");

endmodule

>>> hw/rtl/ezvad_back.sv
// ----------------------------------------------------------------------------
// ezvad_back
// Decision unit: takes one frame record at a time, forms the threshold
// products over two multiply steps, applies the activity and hangover rules
// and presents the result in an output register.
// ----------------------------------------------------------------------------
module ezvad_back #(
   parameter int unsigned MAX_FRAME_LEN = 4096,
   localparam int unsigned CNT_W = $clog2(MAX_FRAME_LEN + 1),
   localparam int unsigned CRS_W = $clog2(MAX_FRAME_LEN),
   localparam int unsigned SUM_W = 30 + CNT_W,
   localparam int unsigned REC_W = SUM_W + CNT_W + CRS_W,
   localparam int unsigned CMP_W = SUM_W + 2,
   localparam int unsigned ZN_W  = 17 + CNT_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ezvad_pkg::cfg_type      cfg,
   input  ezvad_pkg::q_status_type q_status,
   input  logic [REC_W-1:0]        q_rdata,
   output logic                    q_pop,
   output logic                    rsp_valid,
   output ezvad_pkg::rsp_type      rsp_data,
   input  logic                    rsp_stall
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_DECIDE
   } state_type;

   state_type          state_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [CRS_W-1:0]   c_ff;
   logic [31:0]        tsq_ff;
   logic [ZN_W-1:0]    zn_ff;
   logic [CMP_W-1:0]   tn_ff;
   logic [1:0]         active_run_ff;
   logic [7:0]         silent_run_ff;
   logic               speaking_ff;
   logic               rsp_valid_ff;
   ezvad_pkg::rsp_type rsp_data_ff;

   logic               loud, voiced, low_zcr, active;
   logic               load;
   logic [1:0]         active_run_in;
   logic [7:0]         silent_run_in;
   logic               speaking_in;

   assign q_pop = (state_ff == ST_IDLE) && !q_status.empty;
   assign load  = (state_ff == ST_DECIDE) && (!rsp_valid_ff || !rsp_stall);

   // Exact cross-multiplied forms of the RMS and crossing-rate tests.
   assign loud    = CMP_W'(sum_ff) > tn_ff;
   assign voiced  = {sum_ff, 2'b00} > tn_ff;
   assign low_zcr = ZN_W'({c_ff, 16'd0}) < zn_ff;
   assign active  = loud || (voiced && low_zcr);

   always_comb begin
      active_run_in = active_run_ff;
      silent_run_in = silent_run_ff;
      speaking_in   = speaking_ff;
      if (active) begin
         if (active_run_ff < ezvad_pkg::ACTIVE_RUN_SPEAK) begin
            active_run_in = active_run_ff + 2'd1;
         end
         silent_run_in = 8'd0;
         if (active_run_in >= ezvad_pkg::ACTIVE_RUN_SPEAK) begin
            speaking_in = 1'b1;
         end
      end else begin
         if (silent_run_ff < ezvad_pkg::SILENT_RUN_MAX) begin
            silent_run_in = silent_run_ff + 8'd1;
         end
         active_run_in = 2'd0;
         if (silent_run_in >= cfg.hangover_frames) begin
            speaking_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_run_ff <= 2'd0;
         silent_run_ff <= 8'd0;
         speaking_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  {sum_ff, n_ff, c_ff} <= q_rdata;
                  state_ff             <= ST_MUL1;
               end
            end
            ST_MUL1: begin
               tsq_ff   <= {16'd0, cfg.energy_threshold} * {16'd0, cfg.energy_threshold};
               zn_ff    <= ZN_W'(cfg.zcr_threshold) * ZN_W'(n_ff);
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               tn_ff    <= CMP_W'(tsq_ff) * CMP_W'(n_ff);
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (load) begin
                  active_run_ff            <= active_run_in;
                  silent_run_ff            <= silent_run_in;
                  speaking_ff              <= speaking_in;
                  rsp_data_ff.speaking     <= speaking_in;
                  rsp_data_ff.frame_voice  <= active;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_decide_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && rsp_valid_ff && rsp_stall) |=> state_ff == ST_DECIDE)
      else $error("decision left while the output register was still occupied");

   a_speech_needs_activity: assert property (@(posedge clock) disable iff (reset)
      (load && speaking_in && !active) |-> speaking_ff)
      else $error("speech declared on a silent frame");

   a_active_run_saturates: assert property (@(posedge clock) disable iff (reset)
      active_run_ff != 2'd3)
      else $error("active run counter passed its saturation value");

endmodule

>>> hw/rtl/energy_zcr_voice_activity_detector_core.sv
// ----------------------------------------------------------------------------
// energy_zcr_voice_activity_detector_core
// Throughput: one sample per cycle while req_stall is low; the decision unit
// runs its two-step multiply sequence once per frame, and the two-entry frame
// queue absorbs short frames until it fills. Synchronous active-high reset
// restores the register defaults and clears all frame and speech state.
// ----------------------------------------------------------------------------
module energy_zcr_voice_activity_detector_core #(
   parameter int unsigned MAX_FRAME_LEN = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  ezvad_pkg::req_type   req_data,
   output logic                 req_stall,
   output logic                 rsp_valid,
   output ezvad_pkg::rsp_type   rsp_data,
   input  logic                 rsp_stall,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int unsigned CNT_W = $clog2(MAX_FRAME_LEN + 1);
   localparam int unsigned CRS_W = $clog2(MAX_FRAME_LEN);
   localparam int unsigned REC_W = 30 + CNT_W + CNT_W + CRS_W;

   ezvad_pkg::cfg_type      cfg_ff;
   ezvad_pkg::q_status_type q_status;
   logic                    q_push, q_pop;
   logic [REC_W-1:0]        q_wdata, q_rdata;
   logic                    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.energy_threshold <= ezvad_pkg::ENERGY_THRESHOLD_RESET;
         cfg_ff.zcr_threshold    <= ezvad_pkg::ZCR_THRESHOLD_RESET;
         cfg_ff.hangover_frames  <= ezvad_pkg::HANGOVER_FRAMES_RESET;
      end else if (wr_en) begin
         case (paddr[3:2])
            ezvad_pkg::REG_ENERGY_THRESHOLD: cfg_ff.energy_threshold <= pwdata[15:0];
            ezvad_pkg::REG_ZCR_THRESHOLD:    cfg_ff.zcr_threshold    <= pwdata[16:0];
            ezvad_pkg::REG_HANGOVER_FRAMES:  cfg_ff.hangover_frames  <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         ezvad_pkg::REG_ENERGY_THRESHOLD: prdata = {16'd0, cfg_ff.energy_threshold};
         ezvad_pkg::REG_ZCR_THRESHOLD:    prdata = {15'd0, cfg_ff.zcr_threshold};
         ezvad_pkg::REG_HANGOVER_FRAMES:  prdata = {24'd0, cfg_ff.hangover_frames};
         default:                         prdata = 32'd0;
      endcase
   end

   ezvad_front #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   ezvad_queue #(
      .WIDTH (REC_W)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   ezvad_back #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

>>> tb/vad_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_frame_checker
// Watches the sample, decision and register ports of the voice activity
// detector. It keeps its own copy of the frame accumulators, the speech state
// and the registers, predicts the decision of every closed frame and compares
// each decision transfer and each register read with that prediction.
// ----------------------------------------------------------------------------
module vad_frame_checker #(
   parameter int unsigned MAX_FRAME_LEN = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  ezvad_pkg::req_type req_data,
   input  logic               req_stall,
   input  logic               rsp_valid,
   input  ezvad_pkg::rsp_type rsp_data,
   input  logic               rsp_stall,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic [31:0]        prdata,
   input  logic               pready,
   output int                 mismatches,
   output int                 outstanding
);

   ezvad_pkg::cfg_type settings;
   logic [42:0]        energy_sum;
   logic [12:0]        frame_len;
   logic [11:0]        crossings;
   logic               was_negative;
   logic [1:0]         active_streak;
   logic [7:0]         silent_streak;
   logic               speech_on;
   ezvad_pkg::rsp_type expected_decisions[$];

   task automatic note_error(input string what, input logic [31:0] want,
                             input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   // Folds one sample into the frame and, if the frame closes, queues its decision.
   task automatic accumulate_sample(input ezvad_pkg::req_type item);
      logic               neg;
      logic [15:0]        mag;
      logic [63:0]        energy_floor;
      logic               loud;
      logic               voiced;
      logic               low_rate;
      logic               active;
      ezvad_pkg::rsp_type decision;
      neg = item.sample[15];
      mag = neg ? (~item.sample + 16'd1) : item.sample;
      if (frame_len != 0 && neg != was_negative) begin
         crossings++;
      end
      was_negative = neg;
      energy_sum += 43'(mag) * 43'(mag);
      frame_len++;
      if (!item.last_sample && frame_len < MAX_FRAME_LEN) begin
         return;
      end

      energy_floor = 64'(settings.energy_threshold) * 64'(settings.energy_threshold)
                     * 64'(frame_len);
      loud     = 64'(energy_sum) > energy_floor;
      voiced   = (64'(energy_sum) << 2) > energy_floor;
      low_rate = (64'(crossings) << 16) < 64'(settings.zcr_threshold) * 64'(frame_len);
      active   = loud || (voiced && low_rate);

      if (active) begin
         if (active_streak < ezvad_pkg::ACTIVE_RUN_SPEAK) begin
            active_streak++;
         end
         silent_streak = '0;
         if (active_streak >= ezvad_pkg::ACTIVE_RUN_SPEAK) begin
            speech_on = 1'b1;
         end
      end else begin
         if (silent_streak < ezvad_pkg::SILENT_RUN_MAX) begin
            silent_streak++;
         end
         active_streak = '0;
         if (silent_streak >= settings.hangover_frames) begin
            speech_on = 1'b0;
         end
      end

      decision.speaking    = speech_on;
      decision.frame_voice = active;
      expected_decisions.push_back(decision);
      energy_sum   = '0;
      frame_len    = '0;
      crossings    = '0;
      was_negative = 1'b0;
   endtask

   always @(posedge clock) begin
      ezvad_pkg::rsp_type want;
      if (reset) begin
         settings.energy_threshold = ezvad_pkg::ENERGY_THRESHOLD_RESET;
         settings.zcr_threshold    = ezvad_pkg::ZCR_THRESHOLD_RESET;
         settings.hangover_frames  = ezvad_pkg::HANGOVER_FRAMES_RESET;
         energy_sum    = '0;
         frame_len     = '0;
         crossings     = '0;
         was_negative  = 1'b0;
         active_streak = '0;
         silent_streak = '0;
         speech_on     = 1'b0;
         expected_decisions.delete();
      end else begin
         if (psel && penable && pready && !pwrite) begin
            case (paddr[3:2])
               ezvad_pkg::REG_ENERGY_THRESHOLD:
                  if (prdata !== 32'(settings.energy_threshold)) begin
                     note_error("energy_threshold read", 32'(settings.energy_threshold),
                                prdata);
                  end
               ezvad_pkg::REG_ZCR_THRESHOLD:
                  if (prdata !== 32'(settings.zcr_threshold)) begin
                     note_error("zcr_threshold read", 32'(settings.zcr_threshold), prdata);
                  end
               ezvad_pkg::REG_HANGOVER_FRAMES:
                  if (prdata !== 32'(settings.hangover_frames)) begin
                     note_error("hangover_frames read", 32'(settings.hangover_frames),
                                prdata);
                  end
               default: ;
            endcase
         end

         if (psel && penable && pready && pwrite) begin
            case (paddr[3:2])
               ezvad_pkg::REG_ENERGY_THRESHOLD: settings.energy_threshold = pwdata[15:0];
               ezvad_pkg::REG_ZCR_THRESHOLD:    settings.zcr_threshold    = pwdata[16:0];
               ezvad_pkg::REG_HANGOVER_FRAMES:  settings.hangover_frames  = pwdata[7:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            accumulate_sample(req_data);
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_decisions.size() == 0) begin
               note_error("decision with no closed frame", 32'd0, 32'(rsp_data));
            end else begin
               want = expected_decisions.pop_front();
               if (rsp_data.speaking !== want.speaking) begin
                  note_error("speaking", 32'(want.speaking), 32'(rsp_data.speaking));
               end
               if (rsp_data.frame_voice !== want.frame_voice) begin
                  note_error("frame_voice", 32'(want.frame_voice),
                             32'(rsp_data.frame_voice));
               end
            end
         end
      end
      outstanding = expected_decisions.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives audio frames and register settings into the voice activity detector.
// A directed set of boundary frames is followed by random frame bursts under
// several register settings and a long receiver hold-off; the checker beside
// the block predicts and compares every decision.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned MAX_FRAME_LEN    = 4096;
   localparam int unsigned SETTLE_CYCLES    = 12;
   localparam int unsigned WATCHDOG_LIMIT   = 5000;
   localparam int unsigned HOLD_CYCLES      = 300;
   localparam int unsigned SEGMENTS         = 8;
   localparam int unsigned SEGMENT_ITEMS    = 145;
   localparam int unsigned PRESSURE_SEGMENT = 6;
   localparam logic [1:0]  REG_UNUSED       = 2'd3;

   typedef enum int {STYLE_QUIET, STYLE_VOICED, STYLE_LOUD, STYLE_WILD} frame_style_type;
   typedef enum int {SIGNS_ALTERNATE, SIGNS_STEADY, SIGNS_RANDOM} sign_mode_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   ezvad_pkg::req_type req_data  = '0;
   logic               req_stall;
   logic               rsp_valid;
   ezvad_pkg::rsp_type rsp_data;
   logic               rsp_stall = 1'b0;
   logic               psel      = 1'b0;
   logic               penable   = 1'b0;
   logic               pwrite    = 1'b0;
   logic [3:0]         paddr     = '0;
   logic [31:0]        pwdata    = '0;
   logic [31:0]        prdata;
   logic               pready;

   int          mismatches;
   int          outstanding;
   int unsigned req_gap_pct = 0;
   int unsigned rsp_gap_pct = 0;
   int unsigned energy_setting = 500;
   logic        hold_go = 1'b0;
   logic        hold_on = 1'b0;
   int unsigned quiet_cycles = 0;

   energy_zcr_voice_activity_detector_core #(
      .MAX_FRAME_LEN(MAX_FRAME_LEN)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_data(req_data), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   vad_frame_checker #(
      .MAX_FRAME_LEN(MAX_FRAME_LEN)
   ) checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_data(req_data), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_on || ($urandom_range(99) < rsp_gap_pct);
      end
   end

   // The long hold-off lets results pile up so that the block stalls its input.
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic send_sample(input logic signed [15:0] value, input logic last);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{sample: value, last_sample: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [1:0] index,
                             input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Writes all three registers with random bits above each field, pokes the
   // unused slot and reads the three registers back.
   task automatic apply_settings(input int unsigned energy, input int unsigned zcr,
                                 input int unsigned hangover);
      csr_access(1'b1, ezvad_pkg::REG_ENERGY_THRESHOLD, {16'($urandom), 16'(energy)});
      csr_access(1'b1, ezvad_pkg::REG_ZCR_THRESHOLD, {15'($urandom), 17'(zcr)});
      csr_access(1'b1, ezvad_pkg::REG_HANGOVER_FRAMES, {24'($urandom), 8'(hangover)});
      csr_access(1'b1, REG_UNUSED, $urandom);
      csr_access(1'b0, ezvad_pkg::REG_ENERGY_THRESHOLD, '0);
      csr_access(1'b0, ezvad_pkg::REG_ZCR_THRESHOLD, '0);
      csr_access(1'b0, ezvad_pkg::REG_HANGOVER_FRAMES, '0);
      energy_setting = energy & 16'hFFFF;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Magnitudes scale with the current energy threshold, except in STYLE_WILD.
   task automatic send_frame(input int unsigned len, input frame_style_type style,
                             input sign_mode_type signs);
      int unsigned lo;
      int unsigned hi;
      int unsigned mag;
      logic        neg;
      logic [15:0] pattern;
      case (style)
         STYLE_QUIET: begin
            lo = 0;
            hi = energy_setting / 3;
         end
         STYLE_VOICED: begin
            lo = energy_setting / 2;
            hi = energy_setting;
         end
         STYLE_LOUD: begin
            lo = energy_setting;
            hi = energy_setting * 3;
         end
         default: begin
            lo = 0;
            hi = 32768;
         end
      endcase
      if (hi > 32768) hi = 32768;
      if (lo > hi) lo = hi;
      neg = 1'($urandom_range(1));
      for (int unsigned i = 0; i < len; i++) begin
         mag = $urandom_range(hi, lo);
         if (signs == SIGNS_ALTERNATE) begin
            neg = ~neg;
         end else if (signs == SIGNS_RANDOM) begin
            neg = 1'($urandom_range(1));
         end
         if (neg) begin
            pattern = 16'(-int'(mag));
         end else begin
            pattern = 16'((mag > 32767) ? 32767 : mag);
         end
         send_sample(pattern, i == len - 1);
      end
   endtask

   initial begin
      int unsigned     sent;
      int unsigned     len;
      int unsigned     pick;
      int unsigned     mood_left;
      logic            in_speech;
      frame_style_type style;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      req_gap_pct <= 9;
      rsp_gap_pct <= 52;

      // Reset values, then boundary frames under them.
      csr_access(1'b0, ezvad_pkg::REG_ENERGY_THRESHOLD, '0);
      csr_access(1'b0, ezvad_pkg::REG_ZCR_THRESHOLD, '0);
      csr_access(1'b0, ezvad_pkg::REG_HANGOVER_FRAMES, '0);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sd32767, 1'b0);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh8000, 1'b1);
      // Energy exactly at the threshold, then exactly at half of it.
      send_sample(16'sd500, 1'b0);
      send_sample(16'sd500, 1'b1);
      send_sample(16'sd500, 1'b0);
      send_sample(-16'sd500, 1'b1);
      send_sample(16'sd250, 1'b0);
      send_sample(16'sd250, 1'b1);
      send_sample(16'sd251, 1'b1);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd1, 1'b1);
      send_sample(16'sd0, 1'b0);
      send_sample(-16'sd600, 1'b0);
      send_sample(16'sd0, 1'b1);
      drain();

      in_speech = 1'b0;
      mood_left = 0;
      for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: apply_settings(0, 0, 0);
            1: apply_settings(65535, 131071, 255);
            2: apply_settings(32768, 65536, 1);
            default: apply_settings($urandom_range(3000, 20), $urandom_range(65536, 0),
                                    $urandom_range(10, 0));
         endcase
         if (seg < 3) begin
            req_gap_pct <= 9;
            rsp_gap_pct <= 52;
         end else if (seg < 6) begin
            req_gap_pct <= 52;
            rsp_gap_pct <= 9;
         end else begin
            req_gap_pct <= 0;
            rsp_gap_pct <= 0;
         end
         if (seg == PRESSURE_SEGMENT) begin
            hold_go <= 1'b1;
         end

         sent = 0;
         while (sent < SEGMENT_ITEMS) begin
            if (mood_left == 0) begin
               in_speech = ~in_speech;
               mood_left = $urandom_range(12, 1);
            end
            mood_left--;
            pick = $urandom_range(99);
            if (in_speech) begin
               style = (pick < 50) ? STYLE_LOUD : (pick < 85) ? STYLE_VOICED : STYLE_WILD;
            end else begin
               style = (pick < 70) ? STYLE_QUIET : (pick < 85) ? STYLE_VOICED : STYLE_WILD;
            end
            pick = $urandom_range(99);
            if (pick < 80) begin
               len = $urandom_range(8, 1);
            end else if (pick < 95) begin
               len = $urandom_range(40, 9);
            end else begin
               len = $urandom_range(200, 41);
            end
            send_frame(len, style, sign_mode_type'($urandom_range(2)));
            sent += len;
         end
         drain();
      end

      @(negedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
